>>> src/pid_controller_with_feedforward_defines.svh
// ----------------------------------------------------------------------------
// pid_controller_with_feedforward_defines
// assertion macros for the checker file of the pid block
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_WITH_FEEDFORWARD_DEFINES_SVH
`define PID_CONTROLLER_WITH_FEEDFORWARD_DEFINES_SVH

// check sampled on clk, switched off while rst is high
`define PIDFF_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check sampled on clk that also holds during reset
`define PIDFF_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pidff_pkg.sv
// ----------------------------------------------------------------------------
// pidff_pkg
// shared constants, register indexes and the configuration struct
// ----------------------------------------------------------------------------
package pidff_pkg;

  // default sample width and gain fraction bits
  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 8;

  // fixed field widths
  localparam int GAIN_W     = 16;
  localparam int ACC_W      = 32;
  localparam int LIMIT_W    = 31;
  localparam int DZ_W       = 16;
  localparam int DRIVE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN         = 3'd0,
    REG_I_GAIN         = 3'd1,
    REG_D_GAIN         = 3'd2,
    REG_FF_GAIN        = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_OUT_LIMIT      = 3'd5,
    REG_DEADBAND       = 3'd6,
    REG_DERIV_ON_MEAS  = 3'd7
  } cfg_reg_t;

  // configuration register set
  typedef struct packed {
    logic signed [GAIN_W-1:0]  p_gain;
    logic signed [GAIN_W-1:0]  i_gain;
    logic signed [GAIN_W-1:0]  d_gain;
    logic signed [GAIN_W-1:0]  ff_gain;
    logic        [LIMIT_W-1:0] integral_limit;
    logic        [LIMIT_W-1:0] out_limit;
    logic        [DZ_W-1:0]    deadband;
    logic                      derivative_on_measurement;
  } cfg_t;

endpackage

>>> src/pidff_in_if.sv
// ----------------------------------------------------------------------------
// pidff_in_if
// sample channel: target, measured value and restart flag
// ----------------------------------------------------------------------------
interface pidff_in_if #(
  parameter int SAMPLE_WIDTH = pidff_pkg::SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] target;
  logic signed [SAMPLE_WIDTH-1:0] measured;
  logic                           restart;

  modport source (output valid, output target, output measured, output restart, input ready);
  modport sink   (input valid, input target, input measured, input restart, output ready);
endinterface

>>> src/pidff_out_if.sv
// ----------------------------------------------------------------------------
// pidff_out_if
// actuation channel: one drive value per sample
// ----------------------------------------------------------------------------
interface pidff_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pidff_pkg::DRIVE_W-1:0]     drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

>>> src/pid_controller_with_feedforward.sv
// ----------------------------------------------------------------------------
// pid_controller_with_feedforward
// discrete pid controller with dead zone, clamped integral and feedforward
// ----------------------------------------------------------------------------
//
//   channel    dir  payload                       transfer when
//   sample     in   target, measured, restart     valid && ready
//   actuation  out  drive                         valid && ready
//   cfg        in   cfg_index, cfg_wdata          cfg_we
//
// Takes one sample per cycle unless stalled from the actuation side; a drive value
// passes the input, error, integral/operand, product and result registers.
// The integral accumulator closes its loop within the integral stage, so
// back-to-back samples see each other's sum with no wait.
// A stalled result holds the result register; earlier stages keep filling until full.
// Synchronous reset clears valids, history, integral and configuration, not data registers.
//
module pid_controller_with_feedforward #(
  parameter int SAMPLE_WIDTH   = pidff_pkg::SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = pidff_pkg::GAIN_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  pidff_in_if.sink                            sample,
  pidff_out_if.source                         actuation,
  input  logic                                cfg_we,
  input  logic [pidff_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidff_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  pidff_pkg::cfg_t cfg;

  logic                         err_valid;
  logic                         err_ready;
  logic signed [SAMPLE_WIDTH:0] err;
  logic signed [SAMPLE_WIDTH:0] err_last;
  logic signed [SAMPLE_WIDTH:0] meas_diff;
  logic signed [SAMPLE_WIDTH:0] target_diff;
  logic                         err_restart;

  logic prod_valid;
  logic prod_ready;
  logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH:0]       p_prod;
  logic signed [pidff_pkg::GAIN_W+pidff_pkg::ACC_W-1:0] i_prod;
  logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH+1:0]     d_prod;
  logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH:0]       f_prod;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (pidff_pkg::cfg_reg_t'(cfg_index))
        pidff_pkg::REG_P_GAIN: begin
          cfg.p_gain <= cfg_wdata[pidff_pkg::GAIN_W-1:0];
        end
        pidff_pkg::REG_I_GAIN: begin
          cfg.i_gain <= cfg_wdata[pidff_pkg::GAIN_W-1:0];
        end
        pidff_pkg::REG_D_GAIN: begin
          cfg.d_gain <= cfg_wdata[pidff_pkg::GAIN_W-1:0];
        end
        pidff_pkg::REG_FF_GAIN: begin
          cfg.ff_gain <= cfg_wdata[pidff_pkg::GAIN_W-1:0];
        end
        pidff_pkg::REG_INTEGRAL_LIMIT: begin
          cfg.integral_limit <= cfg_wdata[pidff_pkg::LIMIT_W-1:0];
        end
        pidff_pkg::REG_OUT_LIMIT: begin
          cfg.out_limit <= cfg_wdata[pidff_pkg::LIMIT_W-1:0];
        end
        pidff_pkg::REG_DEADBAND: begin
          cfg.deadband <= cfg_wdata[pidff_pkg::DZ_W-1:0];
        end
        pidff_pkg::REG_DERIV_ON_MEAS: begin
          cfg.derivative_on_measurement <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // error and history
  pidff_error #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_error (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .in_target   (sample.target),
    .in_measured (sample.measured),
    .in_restart  (sample.restart),
    .deadband    (cfg.deadband),
    .err_valid   (err_valid),
    .err_ready   (err_ready),
    .err         (err),
    .err_last    (err_last),
    .meas_diff   (meas_diff),
    .target_diff (target_diff),
    .err_restart (err_restart)
  );

  // integral and products
  pidff_terms #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_terms (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .err_valid   (err_valid),
    .err_ready   (err_ready),
    .err         (err),
    .err_last    (err_last),
    .meas_diff   (meas_diff),
    .target_diff (target_diff),
    .err_restart (err_restart),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .p_prod      (p_prod),
    .i_prod      (i_prod),
    .d_prod      (d_prod),
    .f_prod      (f_prod)
  );

  // sum, clamp and result
  pidff_output #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_output (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .p_prod     (p_prod),
    .i_prod     (i_prod),
    .d_prod     (d_prod),
    .f_prod     (f_prod),
    .actuation  (actuation)
  );

endmodule

>>> src/pidff_error.sv
// ----------------------------------------------------------------------------
// pidff_error
// input register, error with dead zone, and sample history
// ----------------------------------------------------------------------------
module pidff_error #(
  parameter int SAMPLE_WIDTH = pidff_pkg::SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample side
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_target,
  input  logic signed [SAMPLE_WIDTH-1:0] in_measured,
  input  logic                           in_restart,
  input  logic [pidff_pkg::DZ_W-1:0]     deadband,
  // toward the integral stage
  output logic                           err_valid,
  input  logic                           err_ready,
  output logic signed [SAMPLE_WIDTH:0]   err,
  output logic signed [SAMPLE_WIDTH:0]   err_last,
  output logic signed [SAMPLE_WIDTH:0]   meas_diff,
  output logic signed [SAMPLE_WIDTH:0]   target_diff,
  output logic                           err_restart
);

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int CW = (EW > pidff_pkg::DZ_W) ? EW : pidff_pkg::DZ_W;

  logic                           v0;
  logic signed [SAMPLE_WIDTH-1:0] tgt0;
  logic signed [SAMPLE_WIDTH-1:0] meas0;
  logic                           restart0;
  logic                           ready0;
  logic                           ready1;
  logic                           advance1;

  logic signed [SAMPLE_WIDTH-1:0] last_target;
  logic signed [SAMPLE_WIDTH-1:0] last_measured;
  logic signed [EW-1:0]           last_error;

  logic signed [SAMPLE_WIDTH-1:0] lt_sel;
  logic signed [SAMPLE_WIDTH-1:0] lm_sel;
  logic signed [EW-1:0]           le_sel;
  logic signed [EW-1:0]           e_raw;
  logic        [EW-1:0]           mag;
  logic signed [EW-1:0]           e_dz;

  // stage hand-off: a stage takes a transfer when empty or draining
  assign ready1   = !err_valid || err_ready;
  assign ready0   = !v0 || ready1;
  assign in_ready = ready0;
  assign advance1 = v0 && ready1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0 && in_valid) begin
      tgt0     <= in_target;
      meas0    <= in_measured;
      restart0 <= in_restart;
    end
  end

  // history as seen by this sample, cleared by restart
  assign lt_sel = restart0 ? '0 : last_target;
  assign lm_sel = restart0 ? '0 : last_measured;
  assign le_sel = restart0 ? '0 : last_error;

  // error and dead zone
  assign e_raw = EW'(tgt0) - EW'(meas0);
  assign mag   = e_raw[EW-1] ? unsigned'(-e_raw) : unsigned'(e_raw);
  assign e_dz  = (CW'(mag) < CW'(deadband)) ? '0 : e_raw;

  // error stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid <= 1'b0;
    end else if (ready1) begin
      err_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance1) begin
      err         <= e_dz;
      err_last    <= le_sel;
      meas_diff   <= EW'(lm_sel) - EW'(meas0);
      target_diff <= EW'(tgt0) - EW'(lt_sel);
      err_restart <= restart0;
    end
  end

  // sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      last_target   <= '0;
      last_measured <= '0;
      last_error    <= '0;
    end else if (advance1) begin
      last_target   <= tgt0;
      last_measured <= meas0;
      last_error    <= e_dz;
    end
  end

endmodule

>>> src/pidff_terms.sv
// ----------------------------------------------------------------------------
// pidff_terms
// integral accumulator with clamp, derivative operand, and gain products
// ----------------------------------------------------------------------------
module pidff_terms #(
  parameter int SAMPLE_WIDTH = pidff_pkg::SAMPLE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pidff_pkg::cfg_t              cfg,
  // from the error stage
  input  logic                         err_valid,
  output logic                         err_ready,
  input  logic signed [SAMPLE_WIDTH:0] err,
  input  logic signed [SAMPLE_WIDTH:0] err_last,
  input  logic signed [SAMPLE_WIDTH:0] meas_diff,
  input  logic signed [SAMPLE_WIDTH:0] target_diff,
  input  logic                         err_restart,
  // products toward the output stage
  output logic                         prod_valid,
  input  logic                         prod_ready,
  output logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH:0]   p_prod,
  output logic signed [pidff_pkg::GAIN_W+pidff_pkg::ACC_W-1:0] i_prod,
  output logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH+1:0] d_prod,
  output logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH:0]   f_prod
);

  localparam int EW  = SAMPLE_WIDTH + 1;
  localparam int AW  = pidff_pkg::ACC_W;
  localparam int AXW = AW + 2;

  logic                 v2;
  logic                 ready2;
  logic                 ready3;
  logic                 advance2;
  logic                 advance3;

  logic signed [AW-1:0]  integral_sum;
  logic signed [AW-1:0]  isum_prev;
  logic signed [AXW-1:0] isum_raw;
  logic signed [AXW-1:0] ilim_hi;
  logic signed [AXW-1:0] ilim_lo;
  logic signed [AW-1:0]  isum;
  logic                  ilim_off;
  logic signed [EW:0]    dop;

  logic signed [EW-1:0]  e2;
  logic signed [AW-1:0]  isum2;
  logic signed [EW:0]    dop2;
  logic signed [EW-1:0]  df2;

  // stage hand-off
  assign ready3    = !prod_valid || prod_ready;
  assign ready2    = !v2 || ready3;
  assign err_ready = ready2;
  assign advance2  = err_valid && ready2;
  assign advance3  = v2 && ready3;

  // integral update and clamp; a zero limit leaves only the 32-bit range
  assign isum_prev = err_restart ? '0 : integral_sum;
  assign isum_raw  = AXW'(isum_prev) + AXW'(err);
  assign ilim_off  = (cfg.integral_limit == '0);
  assign ilim_hi   = ilim_off ? AXW'({1'b0, {pidff_pkg::LIMIT_W{1'b1}}})
                              : AXW'({1'b0, cfg.integral_limit});
  assign ilim_lo   = -ilim_hi - AXW'({1'b0, ilim_off});
  assign isum      = (isum_raw > ilim_hi) ? AW'(ilim_hi)
                   : (isum_raw < ilim_lo) ? AW'(ilim_lo) : AW'(isum_raw);

  // derivative operand on measurement or on error
  assign dop = cfg.derivative_on_measurement ? (EW+1)'(meas_diff)
                                             : (EW+1)'(err) - (EW+1)'(err_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (advance2) begin
      integral_sum <= isum;
    end
  end

  // operand stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance2) begin
      e2    <= err;
      isum2 <= isum;
      dop2  <= dop;
      df2   <= target_diff;
    end
  end

  // four gain products, registered
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ready3) begin
      prod_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance3) begin
      p_prod <= cfg.p_gain * e2;
      i_prod <= cfg.i_gain * isum2;
      d_prod <= cfg.d_gain * dop2;
      f_prod <= cfg.ff_gain * df2;
    end
  end

endmodule

>>> src/pidff_output.sv
// ----------------------------------------------------------------------------
// pidff_output
// product scaling, term sum, output clamp and result register
// ----------------------------------------------------------------------------
module pidff_output #(
  parameter int SAMPLE_WIDTH   = pidff_pkg::SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = pidff_pkg::GAIN_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  pidff_pkg::cfg_t cfg,
  input  logic            prod_valid,
  output logic            prod_ready,
  input  logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH:0]       p_prod,
  input  logic signed [pidff_pkg::GAIN_W+pidff_pkg::ACC_W-1:0] i_prod,
  input  logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH+1:0]     d_prod,
  input  logic signed [pidff_pkg::GAIN_W+SAMPLE_WIDTH:0]       f_prod,
  pidff_out_if.source     actuation
);

  localparam int OPW   = (pidff_pkg::ACC_W > SAMPLE_WIDTH + 2) ? pidff_pkg::ACC_W
                                                               : SAMPLE_WIDTH + 2;
  localparam int SUM_W = pidff_pkg::GAIN_W + OPW + 2;

  logic                    ready4;
  logic                    advance4;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lim_hi;
  logic signed [SUM_W-1:0] lim_lo;
  logic                    lim_off;
  logic signed [pidff_pkg::DRIVE_W-1:0] drive_next;

  assign ready4     = !actuation.valid || actuation.ready;
  assign prod_ready = ready4;
  assign advance4   = prod_valid && ready4;

  // floor-scaled terms summed at full width
  assign sum = SUM_W'(p_prod >>> GAIN_FRAC_BITS) + SUM_W'(i_prod >>> GAIN_FRAC_BITS)
             + SUM_W'(d_prod >>> GAIN_FRAC_BITS) + SUM_W'(f_prod >>> GAIN_FRAC_BITS);

  // output clamp; a zero limit leaves only the 32-bit range
  assign lim_off    = (cfg.out_limit == '0);
  assign lim_hi     = lim_off ? SUM_W'({1'b0, {pidff_pkg::LIMIT_W{1'b1}}})
                              : SUM_W'({1'b0, cfg.out_limit});
  assign lim_lo     = -lim_hi - SUM_W'({1'b0, lim_off});
  assign drive_next = (sum > lim_hi) ? pidff_pkg::DRIVE_W'(lim_hi)
                    : (sum < lim_lo) ? pidff_pkg::DRIVE_W'(lim_lo)
                    : pidff_pkg::DRIVE_W'(sum);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      actuation.valid <= 1'b0;
    end else if (ready4) begin
      actuation.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance4) begin
      actuation.drive <= drive_next;
    end
  end

endmodule

>>> src/pidff_checker.sv
// ----------------------------------------------------------------------------
// pidff_checker
// port-level checks on the pid block, attached by bind
// ----------------------------------------------------------------------------
`include "pid_controller_with_feedforward_defines.svh"

module pidff_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_ready,
  input logic                                act_valid,
  input logic                                act_ready,
  input logic [pidff_pkg::DRIVE_W-1:0]       act_drive
);

  // reset empties the result register
  `PIDFF_CHECK_ALWAYS(a_reset_empty, rst |=> !act_valid, "result valid after reset")

  // a waiting result keeps its value
  `PIDFF_CHECK(a_hold, act_valid && !act_ready |=> act_valid && $stable(act_drive), "result changed while stalled")

  // with no result waiting the whole pipe can take a sample
  `PIDFF_CHECK(a_ready_free, !act_valid |-> sample_ready, "sample not taken with empty result")

  // a taken sample reaches the result register when the sink keeps taking results
  `PIDFF_CHECK(a_latency, sample_valid && sample_ready && act_ready ##1 act_ready ##1 act_ready ##1 act_ready ##1 act_ready |=> act_valid, "result missing after five cycles")

endmodule

bind pid_controller_with_feedforward pidff_checker u_pidff_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .act_valid    (actuation.valid),
  .act_ready    (actuation.ready),
  .act_drive    (actuation.drive)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pid controller with feedforward: a directed
// table, an integral windup run and randomized register phases, each drive
// value compared against its known table value or an in-bench model of the control law
// ----------------------------------------------------------------------------
module tb_top;
  import pidff_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int FRAC = GAIN_FRAC_BITS;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {ROW_WRITE, ROW_STEP, ROW_STEP_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    cfg_reg_t                sel;
    logic [CFG_DATA_W-1:0]   value;
    logic signed [SW-1:0]    tgt;
    logic signed [SW-1:0]    meas;
    logic                    rs;
    logic signed [DRIVE_W-1:0] drive;
  } table_row_t;

  localparam int DIRECTED_ROWS = 43;

  // directed table: register writes and samples, known drives where obvious
  table_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sh7FFF,   16'sh8000,   1'b0, 32'sd0},
    '{ROW_WRITE,      REG_P_GAIN,         31'h0100,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sh7FFF,   16'sh8000,   1'b1, 32'sd65535},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sh8000,   16'sh7FFF,   1'b1, -32'sd65535},
    '{ROW_WRITE,      REG_P_GAIN,         31'h0001,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          -16'sd1,     16'sd0,      1'b1, -32'sd1},
    '{ROW_WRITE,      REG_P_GAIN,         31'h7FFF,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP,       REG_P_GAIN,         31'd0,          16'sh7FFF,   16'sh8000,   1'b1, 32'sd0},
    '{ROW_WRITE,      REG_P_GAIN,         31'h8000,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP,       REG_P_GAIN,         31'd0,          16'sh7FFF,   16'sh8000,   1'b1, 32'sd0},
    '{ROW_WRITE,      REG_P_GAIN,         31'h0100,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_DEADBAND,       31'd100,        16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd99,     16'sd0,      1'b1, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd100,    16'sd0,      1'b1, 32'sd100},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd0,      16'sd100,    1'b1, -32'sd100},
    '{ROW_WRITE,      REG_DEADBAND,       31'hFFFF,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sh7FFF,   -16'sd32767, 1'b1, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sh7FFF,   16'sh8000,   1'b1, 32'sd65535},
    '{ROW_WRITE,      REG_DEADBAND,       31'd0,          16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_P_GAIN,         31'd0,          16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_I_GAIN,         31'h0100,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_INTEGRAL_LIMIT, 31'd50,         16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd1000,   16'sd0,      1'b1, 32'sd50},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          -16'sd1000,  16'sd0,      1'b0, -32'sd50},
    '{ROW_STEP,       REG_P_GAIN,         31'd0,          16'sd10,     16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_INTEGRAL_LIMIT, 31'h7FFFFFFF,   16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_I_GAIN,         31'd0,          16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_D_GAIN,         31'h0100,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd500,    16'sd0,      1'b1, 32'sd500},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd500,    16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_DERIV_ON_MEAS,  31'd1,          16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd0,      16'sd300,    1'b1, -32'sd300},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd0,      16'sd100,    1'b0, 32'sd200},
    '{ROW_WRITE,      REG_D_GAIN,         31'd0,          16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_FF_GAIN,        31'h0100,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd1234,   16'sd5,      1'b1, 32'sd1234},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd1000,   16'sd5,      1'b0, -32'sd234},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sd1000,   16'sd5,      1'b1, 32'sd1000},
    '{ROW_WRITE,      REG_FF_GAIN,        31'h7FFF,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_WRITE,      REG_OUT_LIMIT,      31'd1000,       16'sd0,      16'sd0,      1'b0, 32'sd0},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sh7FFF,   16'sd0,      1'b1, 32'sd1000},
    '{ROW_STEP_KNOWN, REG_P_GAIN,         31'd0,          16'sh8000,   16'sd0,      1'b0, -32'sd1000}
  };

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pidff_in_if  sample_ch ();
  pidff_out_if act_ch ();

  pid_controller_with_feedforward i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .actuation (act_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register mirror and controller history
  cfg_t                  ctl_regs = '0;
  longint                acc_sum = 0;
  logic signed [SW-1:0]  prev_meas = '0;
  logic signed [SW-1:0]  prev_tgt = '0;
  logic signed [SW:0]    prev_err = '0;

  logic signed [DRIVE_W-1:0] pending_drives [$];
  logic signed [DRIVE_W-1:0] want;
  int   errors = 0;
  logic steady = 1'b0;

  always #5 clk = ~clk;

  function automatic longint clamp_span(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // control law for one sample; updates the history
  function automatic logic signed [DRIVE_W-1:0] predict_drive(
    input logic signed [SW-1:0] tgt,
    input logic signed [SW-1:0] meas,
    input logic                 rs
  );
    longint err, isum, p_term, i_term, d_term, f_term, total;
    if (rs) begin
      acc_sum   = 0;
      prev_meas = '0;
      prev_tgt  = '0;
      prev_err  = '0;
    end
    err = longint'(tgt) - longint'(meas);
    if (((err < 0) ? -err : err) < longint'(ctl_regs.deadband)) begin
      err = 0;
    end
    // integral with its clamp, or plain 32-bit saturation when off
    isum = acc_sum + err;
    if (ctl_regs.integral_limit != '0) begin
      isum = clamp_span(isum, -longint'(ctl_regs.integral_limit),
                        longint'(ctl_regs.integral_limit));
    end else begin
      isum = clamp_span(isum, S32_MIN, S32_MAX);
    end
    acc_sum = isum;
    // shifted products round toward minus infinity
    p_term = (longint'($signed(ctl_regs.p_gain)) * err) >>> FRAC;
    i_term = (longint'($signed(ctl_regs.i_gain)) * isum) >>> FRAC;
    if (ctl_regs.derivative_on_measurement) begin
      d_term = (longint'($signed(ctl_regs.d_gain)) *
                (longint'(prev_meas) - longint'(meas))) >>> FRAC;
    end else begin
      d_term = (longint'($signed(ctl_regs.d_gain)) * (err - longint'(prev_err))) >>> FRAC;
    end
    f_term = (longint'($signed(ctl_regs.ff_gain)) *
              (longint'(tgt) - longint'(prev_tgt))) >>> FRAC;
    total = p_term + i_term + d_term + f_term;
    if (ctl_regs.out_limit != '0) begin
      total = clamp_span(total, -longint'(ctl_regs.out_limit), longint'(ctl_regs.out_limit));
    end else begin
      total = clamp_span(total, S32_MIN, S32_MAX);
    end
    prev_meas = meas;
    prev_tgt  = tgt;
    prev_err  = err[SW:0];
    return total[DRIVE_W-1:0];
  endfunction

  // register write, mirrored at the write edge
  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    case (sel)
      REG_P_GAIN:         ctl_regs.p_gain = data[GAIN_W-1:0];
      REG_I_GAIN:         ctl_regs.i_gain = data[GAIN_W-1:0];
      REG_D_GAIN:         ctl_regs.d_gain = data[GAIN_W-1:0];
      REG_FF_GAIN:        ctl_regs.ff_gain = data[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT: ctl_regs.integral_limit = data[LIMIT_W-1:0];
      REG_OUT_LIMIT:      ctl_regs.out_limit = data[LIMIT_W-1:0];
      REG_DEADBAND:       ctl_regs.deadband = data[DZ_W-1:0];
      REG_DERIV_ON_MEAS:  ctl_regs.derivative_on_measurement = data[0];
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one sample transfer with random idle cycles ahead of it
  task automatic send_sample(
    input logic signed [SW-1:0]      tgt,
    input logic signed [SW-1:0]      meas,
    input logic                      rs,
    input logic                      known,
    input logic signed [DRIVE_W-1:0] known_drive
  );
    logic signed [DRIVE_W-1:0] predicted;
    while (!steady && $urandom_range(99) < 21) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.target   <= tgt;
    sample_ch.measured <= meas;
    sample_ch.restart  <= rs;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = predict_drive(tgt, meas, rs);
    pending_drives.push_back(known ? known_drive : predicted);
  endtask

  task automatic send_run(
    input logic signed [SW-1:0] tgt,
    input logic signed [SW-1:0] meas,
    input logic                 restart_first,
    input int                   count
  );
    for (int n = 0; n < count; n++) begin
      send_sample(tgt, meas, restart_first && (n == 0), 1'b0, '0);
    end
  endtask

  // stop sending, let every outstanding drive come back and the pipe settle
  task automatic drain_pipeline;
    sample_ch.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain(input int ph);
    if (ph == 1) return 16'h7FFF;
    if (ph == 2) return 16'h8000;
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(1024)) - 16'd512;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit(input int ph);
    if (ph == 1) return 31'h7FFFFFFF;
    if (ph == 2) return 31'd1;
    case ($urandom_range(3))
      0:       return 31'd0;
      1:       return 31'($urandom_range(5000, 1));
      2:       return 31'($urandom());
      default: return 31'h7FFFFFFF;
    endcase
  endfunction

  // full register set for one random phase, with junk in the unused bits
  task automatic program_phase(input int ph);
    logic [DZ_W-1:0] dz;
    case ($urandom_range(3))
      0:       dz = '0;
      1:       dz = 16'($urandom_range(300));
      2:       dz = 16'($urandom());
      default: dz = 16'($urandom_range(40));
    endcase
    if (ph == 1) dz = '0;
    if (ph == 2) dz = 16'hFFFF;
    write_reg(REG_P_GAIN,         {15'($urandom()), pick_gain(ph)});
    write_reg(REG_I_GAIN,         {15'($urandom()), pick_gain(ph)});
    write_reg(REG_D_GAIN,         {15'($urandom()), pick_gain(ph)});
    write_reg(REG_FF_GAIN,        {15'($urandom()), pick_gain(ph)});
    write_reg(REG_INTEGRAL_LIMIT, pick_limit(ph));
    write_reg(REG_OUT_LIMIT,      pick_limit(ph));
    write_reg(REG_DEADBAND,       {15'($urandom()), dz});
    write_reg(REG_DERIV_ON_MEAS,  {30'($urandom()), 1'($urandom())});
  endtask

  // receiver stalls at random, none during the steady phases
  always @(posedge clk) begin
    act_ch.ready <= steady || ($urandom_range(99) >= 21);
  end

  // drive transfers against the oldest expectation
  always @(posedge clk) begin
    if (!rst && act_ch.valid && act_ch.ready) begin
      if (pending_drives.size() == 0) begin
        errors++;
        $display("%0t: drive %0d arrived with no sample outstanding", $time, act_ch.drive);
      end else begin
        want = pending_drives.pop_front();
        if (act_ch.drive !== want) begin
          errors++;
          $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, act_ch.drive);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic signed [SW-1:0] tgt, meas;
    logic rs;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.target   <= '0;
    sample_ch.measured <= '0;
    sample_ch.restart  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain_pipeline;
        write_reg(directed_rows[r].sel, directed_rows[r].value);
      end else begin
        send_sample(directed_rows[r].tgt, directed_rows[r].meas, directed_rows[r].rs,
                    directed_rows[r].kind == ROW_STEP_KNOWN, directed_rows[r].drive);
      end
    end

    // integral windup with both clamps off: full integral gain pushes the
    // output onto the upper rail, then a negated gain swings it to the lower
    drain_pipeline;
    write_reg(REG_P_GAIN, '0);
    write_reg(REG_I_GAIN, 31'h7FFF);
    write_reg(REG_D_GAIN, '0);
    write_reg(REG_FF_GAIN, '0);
    write_reg(REG_INTEGRAL_LIMIT, '0);
    write_reg(REG_OUT_LIMIT, '0);
    write_reg(REG_DEADBAND, '0);
    write_reg(REG_DERIV_ON_MEAS, '0);
    send_run(16'sh7FFF, 16'sh8000, 1'b1, 270);
    drain_pipeline;
    write_reg(REG_I_GAIN, 31'h8000);
    send_run(16'sh7FFF, 16'sh8000, 1'b0, 10);

    // random phases, each with its own register set
    for (int ph = 0; ph < 8; ph++) begin
      drain_pipeline;
      program_phase(ph);
      steady = (ph == 4) || (ph == 5);
      for (int n = 0; n < 32; n++) begin
        // hold off mid-phase until every drive is back
        if (ph == 3 && n == 16) drain_pipeline;
        case ($urandom_range(7))
          0: begin
            tgt  = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            meas = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          end
          1, 2: begin
            tgt  = 16'($urandom());
            meas = tgt + 16'($urandom_range(300)) - 16'sd150;
          end
          default: begin
            tgt  = 16'($urandom());
            meas = 16'($urandom());
          end
        endcase
        rs = ($urandom_range(19) == 0);
        send_sample(tgt, meas, rs, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain_pipeline;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
